### rtl/multitap_echo_saturating_assert.svh
// assertion macros for the multi-tap echo checker
`ifndef MULTITAP_ECHO_SATURATING_ASSERT_SVH
`define MULTITAP_ECHO_SATURATING_ASSERT_SVH

// condition in one cycle implies consequence in the next
`define EMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("echo checker: next-cycle property failed");

// condition implies consequence in the same cycle
`define EMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("echo checker: same-cycle property failed");

`endif

### rtl/emt_pkg.sv
// shared constants, types and codes of the multi-tap echo block
package emt_pkg;

    localparam int HIST_AW   = 16;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int MAX_TAPS  = 65;
    localparam int TAP_W     = 7;
    localparam int GAIN_W    = 25;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 15;
    localparam int DIST_W    = CFG_W + 4;
    localparam int OFF_W     = DIST_W + TAP_W;
    localparam int POS_W     = HIST_AW + 1;
    localparam int FRAC_W    = 24;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W     = PROD_W + 6;
    localparam int RES_W     = ACC_W - FRAC_W;
    localparam int GPROD_W   = GAIN_W + 7;
    localparam int RECIP_W   = 26;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;
    // ceil(2^32 / 100)
    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
    localparam logic [6:0] FADE_MAX = 7'd100;
    localparam logic [6:0] PERCENT = 7'd100;

    localparam logic signed [SAMPLE_W-1:0] SAT16_LO = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SAT16_HI = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAT8_LO  = -16'sd128;
    localparam logic signed [SAMPLE_W-1:0] SAT8_HI  = 16'sd127;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_SPACING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_PUSH,
        GS_MUL,
        GS_EST,
        GS_FIX
    } gen_state_t;

    typedef struct packed {
        logic push;
        logic busy;
    } gain_ctl_t;

endpackage

### rtl/emt_gain_cell.sv
// one cell of the gain chain: holds one tap gain, loads from its neighbour
module emt_gain_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head,
    input  logic                        shift,
    input  logic [emt_pkg::GAIN_W-1:0]  d,
    output logic [emt_pkg::GAIN_W-1:0]  q
);
    import emt_pkg::*;

    logic [GAIN_W-1:0] gain_reg;

    // head cell starts at unity gain, the rest at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= head ? GAIN_ONE : '0;
        end
        else if (shift)
        begin
            gain_reg <= d;
        end
    end

    assign q = gain_reg;

endmodule

### rtl/emt_gain_gen.sv
// gain table builder: geometric fade gains and active tap count
module emt_gain_gen (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [6:0]                  echo_count,
    input  logic [6:0]                  fade_percent,
    input  logic                        wide_samples,
    output emt_pkg::gain_ctl_t          ctl,
    output logic [emt_pkg::GAIN_W-1:0]  new_gain,
    output logic [emt_pkg::TAP_W-1:0]   active_taps
);
    import emt_pkg::*;

    gen_state_t           state_reg, state_next;
    logic [TAP_W-1:0]     k_reg, k_next;
    logic [GAIN_W-1:0]    cur_reg, cur_next;
    logic [GPROD_W-1:0]   prod_reg, prod_next;
    logic [GAIN_W-1:0]    est_reg, est_next;
    logic [TAP_W-1:0]     cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic [TAP_W-1:0]     active_reg, active_next;

    logic [6:0]                  fade_eff;
    logic [TAP_W-1:0]            want;
    logic                        hit;
    logic [GPROD_W+RECIP_W-1:0]  recip_prod;
    logic [GPROD_W-1:0]          back_prod;

    // clamp settings
    assign fade_eff = (fade_percent > FADE_MAX) ? FADE_MAX : fade_percent;
    assign want = (echo_count > TAP_W'(MAX_TAPS - 1)) ? TAP_W'(MAX_TAPS - 1) : echo_count;

    // tap still loud enough: fullscale * gain >= one
    assign hit = run_reg && (k_reg < want) &&
                 (wide_samples ? (cur_reg >= GAIN_W'(1 << 9)) : (cur_reg >= GAIN_W'(1 << 17)));

    assign recip_prod = prod_reg * RECIP_100;
    assign back_prod  = GPROD_W'(est_reg) * GPROD_W'(PERCENT);

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        prod_next   = prod_reg;
        est_next    = est_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        active_next = active_reg;
        ctl.push    = 1'b0;
        ctl.busy    = (state_reg != GS_IDLE);
        case (state_reg)
            GS_IDLE:
            begin
            end
            GS_PUSH:
            begin
                ctl.push = 1'b1;
                cnt_next = cnt_reg + TAP_W'(hit);
                run_next = hit;
                if (k_reg == TAP_W'(MAX_TAPS - 1))
                begin
                    active_next = cnt_reg + TAP_W'(hit) + TAP_W'(1);
                    state_next  = GS_IDLE;
                end
                else
                begin
                    k_next     = k_reg + TAP_W'(1);
                    state_next = GS_MUL;
                end
            end
            GS_MUL:
            begin
                prod_next  = GPROD_W'(cur_reg) * GPROD_W'(fade_eff);
                state_next = GS_EST;
            end
            GS_EST:
            begin
                // reciprocal estimate of prod / 100, at most one too high
                est_next   = recip_prod[32 +: GAIN_W];
                state_next = GS_FIX;
            end
            GS_FIX:
            begin
                cur_next   = (back_prod > prod_reg) ? (est_reg - GAIN_W'(1)) : est_reg;
                state_next = GS_PUSH;
            end
            default:
            begin
                state_next = GS_IDLE;
            end
        endcase
        // a register write restarts the build
        if (start)
        begin
            state_next = GS_PUSH;
            k_next     = '0;
            cur_next   = GAIN_ONE;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= GS_IDLE;
            k_reg      <= '0;
            cnt_reg    <= '0;
            run_reg    <= 1'b0;
            active_reg <= TAP_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            run_reg    <= run_next;
            active_reg <= active_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prod_reg <= prod_next;
        est_reg  <= est_next;
    end

    assign new_gain    = cur_reg;
    assign active_taps = active_reg;

endmodule

### rtl/emt_hist_ram.sv
// sample history memory, one write and one registered read per cycle
module emt_hist_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [emt_pkg::HIST_AW-1:0]   waddr,
    input  logic [emt_pkg::SAMPLE_W-1:0]  wdata,
    input  logic [emt_pkg::HIST_AW-1:0]   raddr,
    output logic [emt_pkg::SAMPLE_W-1:0]  rdata
);
    import emt_pkg::*;

    logic [SAMPLE_W-1:0] mem [HIST_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/multitap_echo_saturating.sv
// Multi-tap echo: each input word yields one output word, the sum of the current sample and up
// to 64 earlier samples spaced echo_spacing*16 apart and faded geometrically, truncated toward
// zero and saturated to 8 or 16 bits. The block steps one tap per cycle through all 65
// gain-chain positions, reading through the single read port of the history memory, then
// drains the multiply-accumulate pipeline and forms the result in the output register. The
// next word is taken only after the result is loaded, which waits while the output is
// stalled. Each register write rebuilds the gain chain, holding input off until the rebuild
// is done.
module multitap_echo_saturating (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [emt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [emt_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [emt_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                  beyond_end,
    input  logic                                  first,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [emt_pkg::SAMPLE_W-1:0]   sample_out
);
    import emt_pkg::*;

    // configuration registers
    logic [6:0]        echo_count_reg;
    logic [CFG_W-1:0]  echo_spacing_reg;
    logic [6:0]        fade_percent_reg;
    logic              wide_samples_reg;
    logic              start_reg;
    logic              cfg_known;

    assign cfg_known = (cfg_index == REG_ECHO_COUNT) || (cfg_index == REG_ECHO_SPACING) ||
                       (cfg_index == REG_FADE_PERCENT) || (cfg_index == REG_WIDE_SAMPLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_count_reg   <= '0;
            echo_spacing_reg <= '0;
            fade_percent_reg <= '0;
            wide_samples_reg <= 1'b0;
            start_reg        <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_we && cfg_known;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ECHO_COUNT:   echo_count_reg   <= cfg_data[6:0];
                    REG_ECHO_SPACING: echo_spacing_reg <= cfg_data;
                    REG_FADE_PERCENT: fade_percent_reg <= cfg_data[6:0];
                    REG_WIDE_SAMPLES: wide_samples_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // gain builder
    gain_ctl_t          gen_ctl;
    logic [GAIN_W-1:0]  new_gain;
    logic [TAP_W-1:0]   active_taps;

    emt_gain_gen u_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start_reg),
        .echo_count   (echo_count_reg),
        .fade_percent (fade_percent_reg),
        .wide_samples (wide_samples_reg),
        .ctl          (gen_ctl),
        .new_gain     (new_gain),
        .active_taps  (active_taps)
    );

    // sequencer state
    seq_state_t         state_reg, state_next;
    logic [TAP_W-1:0]   step_reg;
    logic [OFF_W-1:0]   off_reg;
    logic               live_reg;
    logic [POS_W-1:0]   item_pos_reg;
    logic [HIST_AW-1:0] item_wp_reg;
    logic [HIST_AW-1:0] wp_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               drain_reg;
    logic               out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic               accept;
    logic               running;
    logic               live_now;
    logic               load_out;
    logic [OFF_W-1:0]   tap_step;
    logic [POS_W-1:0]   pos_eff;

    // gain chain, rotating one place per tap
    logic [GAIN_W-1:0] chain_q [MAX_TAPS];
    logic              chain_shift;
    logic [GAIN_W-1:0] tail_d;

    assign chain_shift = gen_ctl.push || running;
    assign tail_d      = gen_ctl.busy ? new_gain : chain_q[0];

    for (genvar i = 0; i < MAX_TAPS; i++)
    begin : g_cell
        emt_gain_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .head  (i == 0),
            .shift (chain_shift),
            .d     ((i == MAX_TAPS - 1) ? tail_d : chain_q[(i + 1) % MAX_TAPS]),
            .q     (chain_q[i])
        );
    end

    // handshake
    assign in_stall = (state_reg != ST_IDLE) || gen_ctl.busy || start_reg || cfg_we;
    assign accept   = in_valid && !in_stall;
    assign running  = (state_reg == ST_RUN);

    // tap qualification: stop at the tap count, the stream start or the history depth
    assign tap_step = OFF_W'({echo_spacing_reg, 4'b0000});
    assign live_now = live_reg && (step_reg < active_taps) &&
                      (off_reg <= OFF_W'(item_pos_reg)) &&
                      (off_reg[OFF_W-1:HIST_AW] == '0);
    assign pos_eff  = first ? '0 : pos_reg;

    // history memory
    logic [HIST_AW-1:0]  raddr;
    logic [SAMPLE_W-1:0] rdata;

    assign raddr = item_wp_reg - off_reg[HIST_AW-1:0];

    emt_hist_ram u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (beyond_end ? '0 : sample_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == TAP_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            live_reg      <= 1'b0;
            wp_reg        <= '0;
            pos_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= (state_reg == ST_DRAIN) && !drain_reg;
            if (accept)
            begin
                step_reg <= '0;
                live_reg <= 1'b1;
                wp_reg   <= wp_reg + HIST_AW'(1);
                pos_reg  <= pos_eff[POS_W-1] ? pos_eff : (pos_eff + POS_W'(1));
            end
            else if (running)
            begin
                step_reg <= step_reg + TAP_W'(1);
                live_reg <= live_now;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item registers and tap offset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg      <= '0;
            item_pos_reg <= pos_eff;
            item_wp_reg  <= wp_reg;
        end
        else if (running)
        begin
            off_reg <= off_reg + tap_step;
        end
    end

    // multiply-accumulate pipeline: read, multiply, add
    logic                       v1_reg, v2_reg;
    logic [GAIN_W-1:0]          g1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= running && live_now;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_reg   <= chain_q[0];
        prod_reg <= $signed(rdata) * $signed({1'b0, g1_reg});
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // truncate toward zero and saturate
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [RES_W-1:0]  trunc;
    logic signed [RES_W-1:0]  lo, hi, sat;

    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
    assign trunc   = acc_adj[ACC_W-1:FRAC_W];
    assign lo      = RES_W'(wide_samples_reg ? SAT16_LO : SAT8_LO);
    assign hi      = RES_W'(wide_samples_reg ? SAT16_HI : SAT8_HI);
    assign sat     = (trunc < lo) ? lo : ((trunc > hi) ? hi : trunc);

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= sat[SAMPLE_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule

### rtl/emt_checker.sv
// port-level checker for the multi-tap echo block, bound to the top level
`include "multitap_echo_saturating_assert.svh"

module emt_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [emt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [emt_pkg::SAMPLE_W-1:0]   sample_out
);
    import emt_pkg::*;

    logic cfg_hit;

    // write to a known register
    assign cfg_hit = cfg_we && ((cfg_index == REG_ECHO_COUNT) ||
                                (cfg_index == REG_ECHO_SPACING) ||
                                (cfg_index == REG_FADE_PERCENT) ||
                                (cfg_index == REG_WIDE_SAMPLES));

    // a held result keeps its value
    `EMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample_out))

    // one word at a time: busy right after acceptance
    `EMT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a register write holds input off while gains rebuild
    `EMT_ASSERT_NEXT(a_busy_after_cfg, clk, rst_n, cfg_hit, in_stall)

    // no acceptance in a write cycle
    `EMT_ASSERT_NOW(a_cfg_stalls, clk, rst_n, cfg_we, in_stall)

endmodule

bind multitap_echo_saturating emt_checker u_emt_checker (.*);

### tb/multitap_echo_saturating_tb.sv
// self-checking testbench for the multi-tap echo block with saturation
module multitap_echo_saturating_tb;
    import emt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       beyond_end;
    logic                       first;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;

    multitap_echo_saturating uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .beyond_end (beyond_end),
        .first      (first),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // echo model state
    logic [6:0]          m_count;
    logic [14:0]         m_spacing;
    logic [6:0]          m_fade;
    logic                m_wide;
    logic [15:0]         echo_hist [HIST_DEPTH];
    int unsigned         echo_pos;
    int unsigned         echo_wp;
    longint unsigned     echo_gain [MAX_TAPS];
    int unsigned         echo_taps;

    logic signed [15:0]  expected_words[$];
    int                  mismatches;
    int                  words_checked;
    int                  words_sent;
    int                  max_depth_tap;

    // rebuild gain chain and active tap count
    function automatic void rebuild_gains();
        longint unsigned fade;
        longint unsigned want;
        longint unsigned full;
        int k;
        fade = (m_fade > FADE_MAX) ? 100 : m_fade;
        want = (m_count > MAX_TAPS - 1) ? MAX_TAPS - 1 : m_count;
        full = m_wide ? 32768 : 128;
        echo_gain[0] = 64'd1 << FRAC_W;
        for (k = 1; k < MAX_TAPS; k++)
            echo_gain[k] = (echo_gain[k-1] * fade) / 100;
        k = 0;
        while (k < want && full * echo_gain[k] >= (64'd1 << FRAC_W))
            k++;
        echo_taps = k + 1;
    endfunction

    // work out the echoed word for one accepted input word
    function automatic logic signed [15:0] echo_word(logic [15:0] raw, logic past_end,
                                                     logic fst);
        longint signed   acc;
        longint signed   res;
        longint signed   lo;
        longint signed   hi;
        longint unsigned tap_step;
        longint unsigned off;
        int unsigned     idx;
        int              j;
        acc      = 0;
        tap_step = longint'(m_spacing) * 16;
        lo       = m_wide ? -32768 : -128;
        hi       = m_wide ? 32767 : 127;
        if (fst)
            echo_pos = 0;
        echo_hist[echo_wp] = past_end ? 16'd0 : raw;
        for (j = 0; j < echo_taps; j++)
        begin
            off = j * tap_step;
            if (off > echo_pos || off >= HIST_DEPTH)
                break;
            if (j > max_depth_tap)
                max_depth_tap = j;
            idx = (echo_wp + HIST_DEPTH - off) % HIST_DEPTH;
            acc += longint'($signed(echo_hist[idx])) * longint'(echo_gain[j]);
        end
        if (acc < 0)
            res = -((-acc) >>> FRAC_W);
        else
            res = acc >>> FRAC_W;
        if (res < lo)
            res = lo;
        if (res > hi)
            res = hi;
        echo_wp = (echo_wp + 1) % HIST_DEPTH;
        if (echo_pos < HIST_DEPTH)
            echo_pos++;
        return res[15:0];
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ECHO_COUNT:   m_count   = val[6:0];
            REG_ECHO_SPACING: m_spacing = val[14:0];
            REG_FADE_PERCENT: m_fade    = val[6:0];
            REG_WIDE_SAMPLES: m_wide    = val[0];
            default: ;
        endcase
        if (idx <= REG_WIDE_SAMPLES)
            rebuild_gains();
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
        idle_cycles(80);
    endtask

    task automatic setup(int unsigned cnt, int unsigned spc, int unsigned fd, bit wd);
        wait_drained();
        write_reg(REG_ECHO_COUNT, cnt);
        write_reg(REG_ECHO_SPACING, spc);
        write_reg(REG_FADE_PERCENT, fd);
        write_reg(REG_WIDE_SAMPLES, wd);
    endtask

    // send one word, with a random gap before it when asked
    task automatic send_word(logic [15:0] s, logic past_end, logic fst, bit gaps);
        if (gaps)
            idle_cycles($urandom_range(0, 15));
        @(posedge clk);
        in_valid   <= 1'b1;
        sample_in  <= s;
        beyond_end <= past_end;
        first      <= fst;
        expected_words.push_back(echo_word(s, past_end, fst));
        words_sent++;
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 1'b0;
    endtask

    // receiver: a random stall, possibly none, before each word
    initial
    begin
        int wait_n;
        out_stall = 1'b0;
        forever
        begin
            wait_n = $urandom_range(0, 15);
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                idle_cycles(wait_n);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word sample_out=%0d", sample_out);
            end
            else
            begin
                if (sample_out !== expected_words[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d mismatch: expected %0d got %0d",
                                 words_checked, expected_words[0], sample_out);
                end
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    task automatic test_passthrough();
        setup(0, 0, 0, 1);
        send_word(16'h7FFF, 0, 1, 0);
        send_word(16'h8000, 0, 0, 0);
        send_word(16'hFFFF, 1, 0, 0);
        send_word(16'h1234, 0, 0, 0);
    endtask

    task automatic test_narrow_saturation();
        // 8-bit mode still sees the full input value
        setup(3, 0, 100, 0);
        send_word(16'h7FFF, 0, 1, 0);
        send_word(16'h8000, 0, 0, 0);
        send_word(16'd100, 0, 0, 0);
        send_word(-16'sd100, 0, 0, 0);
        send_word(16'd50, 0, 0, 0);
    endtask

    task automatic test_short_echo();
        int i;
        // fade over hundred acts as hundred; count over limit capped
        setup(127, 1, 127, 1);
        for (i = 0; i < 40; i++)
            send_word(i[0] ? 16'h8000 : 16'h7FFF, i == 35, i == 0, 0);
        setup(5, 1, 50, 1);
        for (i = 0; i < 30; i++)
            send_word(16'h4000, i > 20, i == 0 || i == 25, 0);
    endtask

    task automatic test_deep_taps();
        // offset beyond history depth is dropped
        setup(3, 16384, 90, 1);
        send_word(16'h1000, 0, 1, 0);
        send_word(16'h0FFF, 0, 0, 0);
    endtask

    // random sequences of well-formed streams
    task automatic test_random(int total);
        int n;
        int len;
        int i;
        int phase;
        logic [15:0] s;
        n = 0;
        phase = 0;
        while (n < total)
        begin
            case (phase % 5)
                0: setup($urandom_range(0, 127), $urandom_range(0, 3),
                         $urandom_range(0, 127), $urandom_range(0, 1));
                1: setup($urandom_range(1, 64), 1, $urandom_range(80, 100), 1);
                2: setup($urandom_range(0, 10), $urandom_range(0, 2),
                         $urandom_range(0, 100), 0);
                3: setup(64, $urandom_range(1, 2), 100, 1);
                default: setup($urandom_range(0, 64), $urandom_range(0, 32767),
                               $urandom_range(0, 100), $urandom_range(0, 1));
            endcase
            phase++;
            len = $urandom_range(30, 140);
            for (i = 0; i < len && n < total; i++)
            begin
                s = $urandom();
                if (!m_wide && $urandom_range(0, 3) != 0)
                    s = 16'($signed($urandom_range(0, 255)) - 128);
                send_word(s, (i > len - 8) || ($urandom_range(0, 30) == 0),
                          (i == 0) || ($urandom_range(0, 60) == 0), 1);
                n++;
                if ($urandom_range(0, 15) == 0)
                    while (expected_words.size() != 0)
                        @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        sample_in  = '0;
        beyond_end = 1'b0;
        first      = 1'b0;
        mismatches = 0;
        words_checked = 0;
        words_sent = 0;
        max_depth_tap = 0;
        m_count = 0;
        m_spacing = 0;
        m_fade = 0;
        m_wide = 0;
        echo_pos = 0;
        echo_wp = 0;
        foreach (echo_gain[k])
            echo_gain[k] = 0;
        rebuild_gains();
        idle_cycles(12);
        rst_n <= 1'b1;
        idle_cycles(300);

        test_passthrough();
        test_narrow_saturation();
        test_short_echo();
        test_deep_taps();
        test_random(620);

        wait_drained();
        $display("%0d words sent, %0d checked, deepest tap reached %0d",
                 words_sent, words_checked, max_depth_tap);
        $display("covered pass-through, 8/16-bit saturation, stream starts, tails, deep taps");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
